// ===== hdl/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

  // widths fixed by the stream and register formats
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int REPL_MAX   = 8;
  localparam int CMDQ_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIND_PATTERN    = 2'd0,
    REG_FIND_LEN        = 2'd1,
    REG_REPLACE_PATTERN = 2'd2,
    REG_REPLACE_LEN     = 2'd3
  } cfg_reg_t;

  // one classified input byte: up to REPL_MAX output beats
  typedef struct packed {
    logic [REPL_MAX-1:0][BYTE_W-1:0] data;
    logic [LEN_W-1:0]                count;
    logic                            last;
    logic                            modified;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/sfr_front.sv =====
`default_nettype none

module sfr_front #(
  parameter int MAX_PATTERN = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfr_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            push,
  input  wire logic [sfr_pkg::BYTE_W-1:0]      in_byte,
  input  wire logic                            is_last,
  output logic                                 full,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output sfr_pkg::cmd_t                        q_cmd
);
  import sfr_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] find_pattern;
  logic [LEN_W-1:0] find_len;
  logic [CFG_W-1:0] replace_pattern;
  logic [LEN_W-1:0] replace_len;

  // window state
  logic [BYTE_W-1:0] window      [MAX_PATTERN];
  logic [BYTE_W-1:0] window_next [MAX_PATTERN];
  logic [BYTE_W-1:0] w_ins       [MAX_PATTERN];
  logic [LEN_W-1:0]  fill, fill_next, fill_ins;
  logic [LEN_W-1:0]  active_len, len_use;
  logic [LEN_W-1:0]  find_clamped, repl_clamped;
  logic              replaced, replaced_next;
  logic              hit, window_full, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  // length clamps
  always_comb begin
    if (find_len == '0) begin
      find_clamped = LEN_W'(1);
    end else if (find_len > LEN_W'(MAX_PATTERN)) begin
      find_clamped = LEN_W'(MAX_PATTERN);
    end else begin
      find_clamped = find_len;
    end
    repl_clamped = (replace_len > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX) : replace_len;
  end

  // pattern length latched when the window starts empty
  assign len_use  = (fill == '0) ? find_clamped : active_len;
  assign fill_ins = fill + LEN_W'(1);

  // window with the new byte placed
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w_ins[i] = (LEN_W'(i) == fill) ? in_byte : window[i];
    end
  end

  // compare the window with the find pattern
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < len_use && w_ins[i] != find_pattern[BYTE_W*i +: BYTE_W]) begin
        hit = 1'b0;
      end
    end
  end

  assign window_full = (fill_ins == len_use);

  // classify the byte into a command for the back end
  always_comb begin
    window_next   = w_ins;
    fill_next     = fill_ins;
    replaced_next = replaced;
    q_cmd         = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      q_cmd.data[i] = w_ins[i];
    end
    if (window_full && hit) begin
      // match: emit the replacement, clear the window
      q_cmd.data    = replace_pattern;
      q_cmd.count   = repl_clamped;
      fill_next     = '0;
      replaced_next = 1'b1;
    end else if (window_full) begin
      // no match: pass the oldest byte, flush the rest on the last beat
      q_cmd.count = is_last ? len_use : LEN_W'(1);
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        window_next[i] = w_ins[i+1];
      end
      fill_next = len_use - LEN_W'(1);
    end else begin
      q_cmd.count = is_last ? fill_ins : '0;
    end
    q_cmd.last     = is_last;
    q_cmd.modified = replaced_next;
    if (is_last) begin
      fill_next     = '0;
      replaced_next = 1'b0;
    end
  end

  assign q_push = accept && (is_last || q_cmd.count != '0);

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      find_pattern    <= '0;
      find_len        <= LEN_W'(1);
      replace_pattern <= '0;
      replace_len     <= '0;
      fill            <= '0;
      active_len      <= LEN_W'(1);
      replaced        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_FIND_PATTERN:    find_pattern    <= cfg_data;
          REG_FIND_LEN:        find_len        <= cfg_data[LEN_W-1:0];
          REG_REPLACE_PATTERN: replace_pattern <= cfg_data;
          REG_REPLACE_LEN:     replace_len     <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        fill       <= fill_next;
        active_len <= len_use;
        replaced   <= replaced_next;
      end
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sfr_cmd_fifo.sv =====
`default_nettype none

module sfr_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire sfr_pkg::cmd_t wr_cmd,
  output logic               q_full,
  input  wire logic          rd_en,
  output logic               rd_valid,
  output sfr_pkg::cmd_t      rd_cmd
);
  import sfr_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             entries [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign q_full   = (count == CNT_W'(CMDQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sfr_back.sv =====
`default_nettype none

module sfr_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire sfr_pkg::cmd_t               q_cmd,
  output logic                             q_pop,
  output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
  output logic                             has_byte,
  output logic                             end_of_run,
  output logic                             modified,
  output logic                             empty,
  input  wire logic                        pop
);
  import sfr_pkg::*;

  localparam int IDX_W = $clog2(REPL_MAX);

  cmd_t             cur;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             at_end, take;

  // current beat is the last one of this command
  assign at_end = (cur.count == '0) || ({1'b0, idx} == cur.count - LEN_W'(1));
  assign take   = busy && pop;
  assign q_pop  = q_valid && (!busy || (take && at_end));

  // result ports
  assign empty      = !busy;
  assign has_byte   = (cur.count != '0);
  assign out_byte   = has_byte ? cur.data[idx] : '0;
  assign end_of_run = cur.last && at_end;
  assign modified   = end_of_run && cur.modified;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // command being serialized
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stream_find_replace_unit.sv =====
// When idle, a taken byte's beat goes through the queue entry, then the serializer register.
// Throughput: one input byte per cycle while each byte yields at most one beat and beats
// are popped as they come; a byte that completes a match holds the output serializer while
// it sends the replacement, and a last byte that flushes the window holds it while it sends the window.
// The output side delivers one beat per cycle while pop is high (single-beat serializer).
// Reset (rst, synchronous): clears the window fill, stream flag, command queue and
// registers to find_len 1, replace_len 0, patterns 0.
`default_nettype none

module stream_find_replace_unit #(
  parameter int MAX_PATTERN = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sfr_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic [sfr_pkg::BYTE_W-1:0]      in_byte,
  input  wire logic                            is_last,
  input  wire logic                            push,
  output logic                                 full,
  output logic [sfr_pkg::BYTE_W-1:0]           out_byte,
  output logic                                 has_byte,
  output logic                                 end_of_run,
  output logic                                 modified,
  output logic                                 empty,
  input  wire logic                            pop
);
  import sfr_pkg::*;

  cmd_t wr_cmd, rd_cmd;
  logic q_full, q_push, q_valid, q_pop;

  // classify each byte against the window
  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_byte   (in_byte),
    .is_last   (is_last),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (wr_cmd)
  );

  // decoupling queue
  sfr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (wr_cmd),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (rd_cmd)
  );

  // serialize commands into beats
  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (rd_cmd),
    .q_pop      (q_pop),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .end_of_run (end_of_run),
    .modified   (modified),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

`default_nettype wire

// ===== hdl/sfr_checker.sv =====
`default_nettype none

module sfr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  input wire logic                            has_byte,
  input wire logic                            end_of_run,
  input wire logic                            modified,
  input wire logic                            empty,
  input wire logic                            pop
);

  // nothing waits on the output right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // an empty marker only closes a stream and carries a zero byte
  a_marker_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (end_of_run && out_byte == '0))
    else $error("empty marker outside end of stream");

  // the modified flag rides only on the final beat
  a_modified_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && modified) |-> end_of_run)
    else $error("modified flag on a non-final beat");

  // a waiting beat holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_run)))
    else $error("waiting result beat changed");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);

`default_nettype wire

// ===== test/stream_find_replace_unit_tb.sv =====
`timescale 1ns / 1ps

module stream_find_replace_unit_tb;
  import sfr_pkg::*;

  // one output beat of the unit
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              eor;
    logic              mod;
  } sfr_beat_t;

  // predicts the output beats of the find/replace unit and checks them in order
  class sfr_scoreboard;
    logic [CFG_W-1:0]  find_pat;
    logic [LEN_W-1:0]  find_len;
    logic [CFG_W-1:0]  repl_pat;
    logic [LEN_W-1:0]  repl_len;
    logic [BYTE_W-1:0] window [8];
    int unsigned       fill;
    int unsigned       active_len;
    bit                seen;
    sfr_beat_t         expected_beats[$];
    int                errors;

    function new();
      find_pat   = '0;
      find_len   = 4'd1;
      repl_pat   = '0;
      repl_len   = 4'd0;
      fill       = 0;
      active_len = 1;
      seen       = 1'b0;
      errors     = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    // clamped find length as the unit would latch it now
    function int unsigned pattern_len();
      if (find_len == 0) return 1;
      if (find_len > 8) return 8;
      return find_len;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FIND_PATTERN:    find_pat = val;
        REG_FIND_LEN:        find_len = val[LEN_W-1:0];
        REG_REPLACE_PATTERN: repl_pat = val;
        REG_REPLACE_LEN:     repl_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted input byte: compute the beats it causes
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      sfr_beat_t   beats [16];
      int          n;
      bit          hit;
      int unsigned rl;
      n = 0;
      if (fill == 0) active_len = pattern_len();
      window[fill] = b;
      fill++;
      // full window: compare with the pattern
      if (fill == active_len) begin
        hit = 1'b1;
        for (int i = 0; i < active_len; i++)
          if (window[i] != find_pat[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          rl = (repl_len > 8) ? 8 : repl_len;
          for (int i = 0; i < rl; i++) begin
            beats[n] = '{repl_pat[8*i +: 8], 1'b1, 1'b0, 1'b0};
            n++;
          end
          fill = 0;
          seen = 1'b1;
        end else begin
          beats[n] = '{window[0], 1'b1, 1'b0, 1'b0};
          n++;
          for (int i = 0; i < 7; i++) window[i] = window[i+1];
          fill--;
        end
      end
      // end of stream: flush the window and mark the last beat
      if (last) begin
        for (int i = 0; i < fill; i++) begin
          beats[n] = '{window[i], 1'b1, 1'b0, 1'b0};
          n++;
        end
        if (n == 0) begin
          beats[0] = '{8'd0, 1'b0, 1'b0, 1'b0};
          n = 1;
        end
        beats[n-1].eor = 1'b1;
        beats[n-1].mod = seen;
        fill = 0;
        seen = 1'b0;
        foreach (window[i]) window[i] = '0;
      end
      for (int i = 0; i < n; i++) expected_beats.push_back(beats[i]);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    // accepted output beat: compare with the oldest prediction
    task check_beat(logic [BYTE_W-1:0] data, logic has, logic eor, logic mod);
      sfr_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat data %02h has %0b eor %0b mod %0b",
                         data, has, eor, mod));
        return;
      end
      want = expected_beats.pop_front();
      if (data !== want.data)
        report($sformatf("out_byte got %02h want %02h", data, want.data));
      if (has !== want.has)
        report($sformatf("has_byte got %0b want %0b", has, want.has));
      if (eor !== want.eor)
        report($sformatf("end_of_run got %0b want %0b", eor, want.eor));
      if (mod !== want.mod)
        report($sformatf("modified got %0b want %0b", mod, want.mod));
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic [BYTE_W-1:0]    in_byte    = '0;
  logic                 is_last    = 1'b0;
  logic                 push       = 1'b0;
  logic                 full;
  logic [BYTE_W-1:0]    out_byte;
  logic                 has_byte;
  logic                 end_of_run;
  logic                 modified;
  logic                 empty;
  logic                 pop        = 1'b0;

  sfr_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 4;
  int rx_cycle   = 0;
  int rx_mode    = 0;

  stream_find_replace_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in_byte),
    .is_last    (is_last),
    .push       (push),
    .full       (full),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .end_of_run (end_of_run),
    .modified   (modified),
    .empty      (empty),
    .pop        (pop)
  );

  always #5 clk = ~clk;

  // receiver stall pattern, with a periodically redrawn random mode
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= (rx_cycle % 4 == 0);
      default: pop <= (rx_cycle % 24 >= 18);
    endcase
  end

  // check every accepted output beat
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_beat(out_byte, has_byte, end_of_run, modified);
  end

  // one input beat, then burst or gap
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    in_byte <= b;
    is_last <= last;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_byte(b, last);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    end
  endtask

  // stop sending and let every predicted beat drain
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // register values biased toward extremes and matchable patterns
  function automatic logic [CFG_W-1:0] random_cfg_value(input cfg_reg_t idx);
    logic [CFG_W-1:0]  val;
    logic [BYTE_W-1:0] sym_a;
    logic [BYTE_W-1:0] sym_b;
    int                pick;
    val   = {$urandom, $urandom};
    sym_a = BYTE_W'($urandom);
    sym_b = BYTE_W'($urandom);
    pick  = $urandom_range(0, 9);
    case (idx)
      REG_FIND_PATTERN: begin
        if (pick == 0) val = '0;
        else if (pick == 1) val = '1;
        else if (pick > 2)
          for (int i = 0; i < 8; i++) val[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
      end
      REG_REPLACE_PATTERN: begin
        if (pick == 0) val = '0;
        else if (pick == 1) val = '1;
      end
      REG_FIND_LEN: begin
        case (pick)
          0: val[3:0] = 4'd0;
          1: val[3:0] = 4'd15;
          2: val[3:0] = 4'd8;
          3: val[3:0] = 4'($urandom_range(9, 15));
          default: val[3:0] = 4'($urandom_range(1, 4));
        endcase
      end
      default: begin
        case (pick)
          0: val[3:0] = 4'd0;
          1: val[3:0] = 4'd15;
          2: val[3:0] = 4'd8;
          3: val[3:0] = 4'($urandom_range(9, 14));
          default: val[3:0] = 4'($urandom_range(0, 4));
        endcase
      end
    endcase
    return val;
  endfunction

  // one stream built from pattern copies, pattern prefixes and stray bytes
  task automatic run_stream(input int nseg, input bit cfg_mid);
    logic [BYTE_W-1:0] bytes[$];
    int                plen;
    int                cut;
    int                pos;
    int                cfg_at;
    plen = sb.pattern_len();
    repeat (nseg) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: for (int k = 0; k < plen; k++) bytes.push_back(sb.find_pat[8*k +: 8]);
        4: begin
          cut = $urandom_range(1, plen);
          for (int k = 0; k < cut; k++) bytes.push_back(sb.find_pat[8*k +: 8]);
        end
        5, 6, 7: begin
          pos = $urandom_range(0, plen - 1);
          bytes.push_back(sb.find_pat[8*pos +: 8]);
        end
        default: bytes.push_back(BYTE_W'($urandom));
      endcase
    end
    cfg_at = (cfg_mid && bytes.size() > 1) ? $urandom_range(1, bytes.size() - 1) : -1;
    for (int k = 0; k < bytes.size(); k++) begin
      // register change while the window may hold bytes
      if (k == cfg_at) begin
        wait_idle();
        pos = $urandom_range(0, 3);
        write_reg(cfg_reg_t'(pos), random_cfg_value(cfg_reg_t'(pos)));
      end
      push_byte(bytes[k], k == bytes.size() - 1);
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: a lone zero byte is deleted, stream ends with an empty marker
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    // longest pattern replaced by the longest replacement on the last byte
    wait_idle();
    write_reg(REG_FIND_PATTERN, 64'h0807_0605_0403_0201);
    write_reg(REG_FIND_LEN, 64'd8);
    write_reg(REG_REPLACE_PATTERN, 64'hF0E1_D2C3_B4A5_9687);
    write_reg(REG_REPLACE_LEN, 64'd8);
    for (int i = 1; i <= 8; i++) push_byte(i[7:0], i == 8);

    // out-of-range lengths: find length zero and replace length above eight
    wait_idle();
    write_reg(REG_FIND_LEN, 64'd0);
    write_reg(REG_FIND_PATTERN, 64'h0000_0000_0000_00FF);
    write_reg(REG_REPLACE_LEN, 64'd12);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h10, 1'b1);

    // find length above eight, then a length change while the window is partly full
    wait_idle();
    write_reg(REG_FIND_PATTERN, 64'h0807_0605_0403_0201);
    write_reg(REG_FIND_LEN, 64'd15);
    write_reg(REG_REPLACE_LEN, 64'd0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h03, 1'b0);
    wait_idle();
    write_reg(REG_FIND_LEN, 64'd2);
    for (int i = 4; i <= 8; i++) push_byte(i[7:0], 1'b0);
    // new length in use now: both bytes deleted, empty end marker
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b1);

    // random phases
    while (items_sent < 440) begin
      wait_idle();
      for (int r = 0; r < 4; r++)
        if ($urandom_range(0, 3) != 0) write_reg(cfg_reg_t'(r), random_cfg_value(cfg_reg_t'(r)));
      repeat ($urandom_range(1, 3)) run_stream($urandom_range(1, 8), $urandom_range(0, 4) == 0);
    end

    // drain
    wait_idle();
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d beats never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
